// ===== rtl/linked_queue_with_detach_defines.svh =====
// Assertion macros shared by the linked queue modules.
// Needs clk and arst_n in the scope of each use.
`ifndef LINKED_QUEUE_WITH_DETACH_DEFINES_SVH
`define LINKED_QUEUE_WITH_DETACH_DEFINES_SVH

// holds at every clock outside reset
`define LQD_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LQD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lqd_pkg.sv =====
// Types and codes for the linked queue with detach.
// No dependencies.
package lqd_pkg;

	localparam int CFG_W = 7;
	localparam int LEN_W = 4;
	localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 7'd64;
	localparam logic [LEN_W-1:0] LEN_MAX = 4'd8;

	localparam logic [1:0] CMD_ENQ = 2'd0;
	localparam logic [1:0] CMD_DEQ = 2'd1;
	localparam logic [1:0] CMD_DET = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_BAD   = 2'd3;

	typedef struct packed {
		logic accept;
		logic commit;
	} lqd_ctrl_t;

endpackage

// ===== rtl/lqd_req_if.sv =====
// Request channel of the linked queue: valid/ready plus command fields.
// Depends on nothing.
interface lqd_req_if #(
	parameter int HW = 6,
	parameter int PW = 64
);
	logic          valid;
	logic          ready;
	logic [1:0]    command;
	logic [PW-1:0] payload;
	logic [3:0]    payload_len;
	logic [HW-1:0] handle;

	modport source (output valid, command, payload, payload_len, handle, input ready);
	modport sink   (input valid, command, payload, payload_len, handle, output ready);
endinterface

// ===== rtl/lqd_rsp_if.sv =====
// Response channel of the linked queue: valid/ready plus result fields.
// Depends on nothing.
interface lqd_rsp_if #(
	parameter int HW = 6,
	parameter int PW = 64,
	parameter int CW = 7
);
	logic          valid;
	logic          ready;
	logic [1:0]    status;
	logic [HW-1:0] result_handle;
	logic [PW-1:0] result_payload;
	logic [3:0]    result_len;
	logic [CW-1:0] occupancy;

	modport source (output valid, status, result_handle, result_payload, result_len, occupancy,
		input ready);
	modport sink   (input valid, status, result_handle, result_payload, result_len, occupancy,
		output ready);
endinterface

// ===== rtl/lqd_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
module lqd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/lqd_ctrl.sv =====
// Controller for the linked queue: request accept, execute, response register valid.
// Depends on lqd_pkg and the assertion macro header.
`include "linked_queue_with_detach_defines.svh"
module lqd_ctrl
	import lqd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output lqd_ctrl_t ctrl
);
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready    = (state_q == S_IDLE);
	assign ctrl.accept = in_valid && in_ready;
	assign ctrl.commit = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (ctrl.accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (ctrl.commit) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`LQD_ASSERT_NEXT(a_accept_exec, ctrl.accept, state_q == S_EXEC, "accept did not start execute")
	`LQD_ASSERT_NEXT(a_commit_valid, ctrl.commit, out_valid_q && state_q == S_IDLE,
		"commit did not load response")
	`LQD_ASSERT_NEXT(a_free_exec, state_q == S_EXEC && !out_valid_q, state_q == S_IDLE,
		"execute stalled with empty response register")
endmodule

// ===== rtl/lqd_dpath.sv =====
// Datapath for the linked queue: head/tail/count, valid bits, free stack,
// link and data RAMs, response register. Depends on lqd_pkg, lqd_ram, macro header.
`include "linked_queue_with_detach_defines.svh"
module lqd_dpath
	import lqd_pkg::*;
#(
	parameter int SLOTS = 64,
	parameter int PW = 64,
	parameter int HW = $clog2(SLOTS),
	parameter int CW = $clog2(SLOTS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lqd_ctrl_t        ctrl,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic [1:0]       command,
	input  logic [PW-1:0]    payload,
	input  logic [LEN_W-1:0] payload_len,
	input  logic [HW-1:0]    handle,
	output logic [1:0]       status,
	output logic [HW-1:0]    result_handle,
	output logic [PW-1:0]    result_payload,
	output logic [LEN_W-1:0] result_len,
	output logic [CW-1:0]    occupancy
);
	localparam int MW = (CW > CFG_W) ? CW : CFG_W;
	localparam int DW = PW + LEN_W;

	// queue state
	logic [CFG_W-1:0] max_q;
	logic [HW-1:0]    head_q, tail_q;
	logic [CW-1:0]    cnt_q, free_top_q, wm_q;
	logic [SLOTS-1:0] valid_q;

	// captured request
	logic [1:0]       cmd_s1;
	logic [PW-1:0]    pay_s1;
	logic [LEN_W-1:0] len_s1;
	logic [HW-1:0]    hnd_s1, tgt_s1;

	// response register
	logic [1:0]       status_q;
	logic [HW-1:0]    rhandle_q;
	logic [PW-1:0]    rpay_q;
	logic [LEN_W-1:0] rlen_q;
	logic [CW-1:0]    occ_q;

	// RAM ports
	logic [HW-1:0] rd_addr, free_raddr;
	logic [HW-1:0] next_rdata, prev_rdata, free_rdata;
	logic [DW-1:0] data_rdata;
	logic          next_we, prev_we, data_we, free_we;
	logic [HW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata, free_waddr;
	logic [DW-1:0] data_wdata;

	// step decode
	logic [CW-1:0]    pop_pos;
	logic             fresh;
	logic [HW-1:0]    new_slot, rel_slot;
	logic             enq_ok, deq_ok, det_ok, oor;
	logic [LEN_W-1:0] len_sat;
	logic [PW-1:0]    pay_mask;

	assign pop_pos    = free_top_q - CW'(1);
	assign free_raddr = pop_pos[HW-1:0];
	assign fresh      = pop_pos < wm_q;
	// below the low-water mark the stack still holds its reset contents
	assign new_slot   = fresh ? (HW'(SLOTS - 1) - pop_pos[HW-1:0]) : free_rdata;
	assign rd_addr    = ctrl.accept ? ((command == CMD_DEQ) ? head_q : handle) : tgt_s1;

	assign oor    = (HW + 1)'(hnd_s1) >= (HW + 1)'(SLOTS);
	assign enq_ok = (cmd_s1 == CMD_ENQ) && !(MW'(cnt_q) >= MW'(max_q)) && (free_top_q != '0);
	assign deq_ok = (cmd_s1 == CMD_DEQ) && (cnt_q != '0);
	assign det_ok = (cmd_s1 == CMD_DET) && !oor && valid_q[hnd_s1];
	assign rel_slot = tgt_s1;

	assign len_sat = (len_s1 > LEN_MAX) ? LEN_MAX : len_s1;

	always_comb begin
		for (int i = 0; i < PW; i++) begin
			pay_mask[i] = LEN_W'(i / 8) < len_sat;
		end
	end

	always_comb begin
		next_we    = 1'b0;
		prev_we    = 1'b0;
		data_we    = ctrl.commit && enq_ok;
		free_we    = ctrl.commit && (deq_ok || det_ok);
		next_waddr = tail_q;
		next_wdata = new_slot;
		prev_waddr = new_slot;
		prev_wdata = tail_q;
		data_wdata = {len_sat, pay_s1 & pay_mask};
		free_waddr = free_top_q[HW-1:0];
		if (ctrl.commit) begin
			if (enq_ok && cnt_q != '0) begin
				next_we = 1'b1;
				prev_we = 1'b1;
			end else if (det_ok && hnd_s1 != head_q && hnd_s1 != tail_q) begin
				// unlink from the middle
				next_we    = 1'b1;
				prev_we    = 1'b1;
				next_waddr = prev_rdata;
				next_wdata = next_rdata;
				prev_waddr = next_rdata;
				prev_wdata = prev_rdata;
			end
		end
	end

	lqd_ram #(.WIDTH(HW), .DEPTH(SLOTS)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.raddr(rd_addr), .rdata(next_rdata)
	);
	lqd_ram #(.WIDTH(HW), .DEPTH(SLOTS)) u_prev_ram (
		.clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
		.raddr(rd_addr), .rdata(prev_rdata)
	);
	lqd_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_data_ram (
		.clk(clk), .we(data_we), .waddr(new_slot), .wdata(data_wdata),
		.raddr(rd_addr), .rdata(data_rdata)
	);
	lqd_ram #(.WIDTH(HW), .DEPTH(SLOTS)) u_free_ram (
		.clk(clk), .we(free_we), .waddr(free_waddr), .wdata(rel_slot),
		.raddr(free_raddr), .rdata(free_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			cmd_s1 <= command;
			pay_s1 <= payload;
			len_s1 <= payload_len;
			hnd_s1 <= handle;
			tgt_s1 <= (command == CMD_DEQ) ? head_q : handle;
		end
		if (ctrl.commit) begin
			status_q  <= STAT_OK;
			rhandle_q <= '0;
			rpay_q    <= '0;
			rlen_q    <= '0;
			occ_q     <= cnt_q;
			if (enq_ok) begin
				rhandle_q <= new_slot;
				occ_q     <= cnt_q + CW'(1);
			end else if (deq_ok || det_ok) begin
				rhandle_q <= rel_slot;
				rpay_q    <= data_rdata[PW-1:0];
				rlen_q    <= data_rdata[DW-1:PW];
				occ_q     <= cnt_q - CW'(1);
			end else begin
				case (cmd_s1)
					CMD_ENQ: status_q <= STAT_FULL;
					CMD_DEQ: status_q <= STAT_EMPTY;
					default: status_q <= STAT_BAD;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q      <= MAX_ENTRIES_RST;
			head_q     <= '0;
			tail_q     <= '0;
			cnt_q      <= '0;
			free_top_q <= CW'(SLOTS);
			wm_q       <= CW'(SLOTS);
			valid_q    <= '0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (ctrl.commit) begin
				if (enq_ok) begin
					valid_q[new_slot] <= 1'b1;
					free_top_q        <= pop_pos;
					if (fresh) begin
						wm_q <= pop_pos;
					end
					cnt_q  <= cnt_q + CW'(1);
					tail_q <= new_slot;
					if (cnt_q == '0) begin
						head_q <= new_slot;
					end
				end else if (deq_ok || det_ok) begin
					valid_q[rel_slot] <= 1'b0;
					free_top_q        <= free_top_q + CW'(1);
					cnt_q             <= cnt_q - CW'(1);
					if (deq_ok || (rel_slot == head_q && rel_slot != tail_q)) begin
						head_q <= next_rdata;
					end else if (rel_slot == tail_q && rel_slot != head_q) begin
						tail_q <= prev_rdata;
					end
				end
			end
		end
	end

	assign status         = status_q;
	assign result_handle  = rhandle_q;
	assign result_payload = rpay_q;
	assign result_len     = rlen_q;
	assign occupancy      = occ_q;

	`LQD_ASSERT_ALWAYS(a_pool_sum,
		(CW + 1)'(free_top_q) + (CW + 1)'(cnt_q) == (CW + 1)'(SLOTS),
		"free slots and queued entries do not add up to the pool")
	`LQD_ASSERT_ALWAYS(a_wm_order, wm_q <= free_top_q, "low-water mark above stack top")
	`LQD_ASSERT_ALWAYS(a_valid_cnt, (CW + 1)'($countones(valid_q)) == (CW + 1)'(cnt_q),
		"valid bits disagree with entry count")
endmodule

// ===== rtl/linked_queue_with_detach.sv =====
// Linked queue with detach: bounded FIFO as a doubly linked list over SLOTS slots.
// An accepted request has its RAM read registered in execute; the commit then loads
// the response register. The next request is accepted only after that commit.
// A response waiting to be taken stalls only the commit of the following request.
// arst_n clears control state at once; no clearing pass, ready once reset is released.
module linked_queue_with_detach
	import lqd_pkg::*;
#(
	parameter int SLOTS = 64,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	lqd_req_if.sink          req,
	lqd_rsp_if.source        rsp
);
	localparam int HW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	lqd_ctrl_t ctrl;

	lqd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.ctrl(ctrl)
	);

	lqd_dpath #(.SLOTS(SLOTS), .PW(PAYLOAD_BITS), .HW(HW), .CW(CW)) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.command(req.command),
		.payload(req.payload),
		.payload_len(req.payload_len),
		.handle(req.handle),
		.status(rsp.status),
		.result_handle(rsp.result_handle),
		.result_payload(rsp.result_payload),
		.result_len(rsp.result_len),
		.occupancy(rsp.occupancy)
	);
endmodule
